[hw/rtl/edc_pkg.sv]
// edc_pkg: field widths, status codes, calendar constants and month/year length
// functions for the epoch day date converter
// no dependencies
package edc_pkg;

    localparam int DayW   = 5;
    localparam int MonthW = 4;
    localparam int YearW  = 12;
    localparam int CountW = 20;
    localparam int StatW  = 2;

    localparam int YearTop = 4095;

    localparam logic KIND_DATE_TO_DAYNUM = 1'b0;
    localparam logic KIND_DAYNUM_TO_DATE = 1'b1;

    localparam logic [StatW-1:0] STATUS_OK        = 2'd0;
    localparam logic [StatW-1:0] STATUS_BAD_DATE  = 2'd1;
    localparam logic [StatW-1:0] STATUS_BAD_COUNT = 2'd2;

    localparam logic [YearW-1:0]  EpochYear     = 12'd1970;
    localparam logic [MonthW-1:0] FirstMonth    = 4'd1;
    localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;

    // residues of the epoch year for the leap rule
    localparam logic [1:0] EpochMod4   = 2'd2;
    localparam logic [6:0] EpochMod100 = 7'd70;
    localparam logic [8:0] EpochMod400 = 9'd370;
    localparam logic [6:0] Mod100Last  = 7'd99;
    localparam logic [8:0] Mod400Last  = 9'd399;

    function automatic logic [8:0] year_len(input logic leap);
        year_len = leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [DayW-1:0] month_len(input logic leap,
                                                  input logic [MonthW-1:0] mon);
        logic [DayW-1:0] len;
        case (mon)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        month_len = len;
    endfunction

endpackage

[hw/rtl/epoch_day_date_converter.sv]
// epoch_day_date_converter: date <-> day number (1970-01-01 is day 1)
// depends on edc_pkg
//
// One item at a time: start is taken while busy is low, and the single result
// shows on the o_ ports for one cycle with o_valid high. The receiver cannot
// stall. All work goes through one shared 20-bit add/subtract unit stepped by
// a small sequencer, one year or one month per cycle. A date (kind 0) is walked
// from 1970 year by year, then month by month; a day number (kind 1) is walked
// down by whole years, then whole months. Inputs that fail the simple field
// checks report in the cycle after start. Leap years are tracked by running
// residue counters, so no divider is needed.
module epoch_day_date_converter #(
    parameter int MAX_YEAR = 4095
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_kind,
    input  logic [edc_pkg::DayW-1:0]      i_in_day,
    input  logic [edc_pkg::MonthW-1:0]    i_in_month,
    input  logic [edc_pkg::YearW-1:0]     i_in_year,
    input  logic [edc_pkg::CountW-1:0]    i_in_count,
    output logic                          o_valid,
    output logic [edc_pkg::StatW-1:0]     o_status,
    output logic [edc_pkg::CountW-1:0]    o_out_count,
    output logic [edc_pkg::DayW-1:0]      o_out_day,
    output logic [edc_pkg::MonthW-1:0]    o_out_month,
    output logic [edc_pkg::YearW-1:0]     o_out_year
);
    import edc_pkg::*;

    localparam logic [YearW-1:0] LastYear =
        YearW'((MAX_YEAR > YearTop) ? YearTop : MAX_YEAR);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_YEAR0 = 5'b00010,
        S_MON0  = 5'b00100,
        S_YEAR1 = 5'b01000,
        S_MON1  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic                r_valid, n_valid;
    logic [DayW-1:0]     r_day, n_day;
    logic [MonthW-1:0]   r_month, n_month;
    logic [YearW-1:0]    r_year_tgt, n_year_tgt;
    logic [YearW:0]      r_year, n_year;
    logic [MonthW-1:0]   r_mon, n_mon;
    logic [CountW-1:0]   r_acc, n_acc;
    logic [1:0]          r_m4, n_m4;
    logic [6:0]          r_m100, n_m100;
    logic [8:0]          r_m400, n_m400;
    logic [StatW-1:0]    r_status, n_status;
    logic [CountW-1:0]   r_out_count, n_out_count;
    logic [DayW-1:0]     r_out_day, n_out_day;
    logic [MonthW-1:0]   r_out_month, n_out_month;
    logic [YearW-1:0]    r_out_year, n_out_year;

    logic                w_leap;
    logic                w_sub;
    logic [CountW-1:0]   w_op;
    logic [CountW:0]     w_sum;
    logic                w_gt;
    logic [YearW:0]      w_year_inc;
    logic                w_bad_fields;

    // shared add/subtract unit
    assign w_leap = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);
    assign w_sub  = (r_state == S_YEAR1) || (r_state == S_MON1);

    always_comb begin
        unique case (r_state)
            S_YEAR0, S_YEAR1: w_op = CountW'(year_len(w_leap));
            S_MON0:           w_op = (r_mon == r_month) ? CountW'(r_day)
                                                        : CountW'(month_len(w_leap, r_mon));
            S_MON1:           w_op = CountW'(month_len(w_leap, r_mon));
            default:          w_op = '0;
        endcase
    end

    assign w_sum = {1'b0, r_acc} + {1'b0, w_op ^ {CountW{w_sub}}} + (CountW+1)'(w_sub);
    assign w_gt  = w_sum[CountW] && (w_sum[CountW-1:0] != '0);
    assign w_year_inc = r_year + 1'b1;

    assign w_bad_fields = (i_in_day == '0) || (i_in_month == '0) ||
                          (i_in_month > MonthsPerYear) || (i_in_year < EpochYear) ||
                          (i_in_year > LastYear);

    always_comb begin
        n_state     = r_state;
        n_valid     = 1'b0;
        n_day       = r_day;
        n_month     = r_month;
        n_year_tgt  = r_year_tgt;
        n_year      = r_year;
        n_mon       = r_mon;
        n_acc       = r_acc;
        n_m4        = r_m4;
        n_m100      = r_m100;
        n_m400      = r_m400;
        n_status    = r_status;
        n_out_count = r_out_count;
        n_out_day   = r_out_day;
        n_out_month = r_out_month;
        n_out_year  = r_out_year;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_day      = i_in_day;
                    n_month    = i_in_month;
                    n_year_tgt = i_in_year;
                    n_year     = {1'b0, EpochYear};
                    n_m4       = EpochMod4;
                    n_m100     = EpochMod100;
                    n_m400     = EpochMod400;
                    if (i_kind == KIND_DATE_TO_DAYNUM) begin
                        n_acc = '0;
                        if (w_bad_fields) begin
                            n_valid     = 1'b1;
                            n_status    = STATUS_BAD_DATE;
                            n_out_count = '0;
                            n_out_day   = '0;
                            n_out_month = '0;
                            n_out_year  = '0;
                        end else begin
                            n_state = S_YEAR0;
                        end
                    end else begin
                        n_acc = i_in_count;
                        if (i_in_count == '0) begin
                            n_valid     = 1'b1;
                            n_status    = STATUS_BAD_COUNT;
                            n_out_count = '0;
                            n_out_day   = '0;
                            n_out_month = '0;
                            n_out_year  = '0;
                        end else begin
                            n_state = S_YEAR1;
                        end
                    end
                end
            end
            S_YEAR0: begin
                if (r_year == {1'b0, r_year_tgt}) begin
                    if (r_day > month_len(w_leap, r_month)) begin
                        n_valid     = 1'b1;
                        n_status    = STATUS_BAD_DATE;
                        n_out_count = '0;
                        n_out_day   = '0;
                        n_out_month = '0;
                        n_out_year  = '0;
                        n_state     = S_IDLE;
                    end else begin
                        n_mon   = FirstMonth;
                        n_state = S_MON0;
                    end
                end else begin
                    n_acc  = w_sum[CountW-1:0];
                    n_year = w_year_inc;
                    n_m4   = r_m4 + 2'd1;
                    n_m100 = (r_m100 == Mod100Last) ? 7'd0 : r_m100 + 7'd1;
                    n_m400 = (r_m400 == Mod400Last) ? 9'd0 : r_m400 + 9'd1;
                end
            end
            S_MON0: begin
                n_acc = w_sum[CountW-1:0];
                if (r_mon == r_month) begin
                    n_valid     = 1'b1;
                    n_status    = STATUS_OK;
                    n_out_count = w_sum[CountW-1:0];
                    n_out_day   = '0;
                    n_out_month = '0;
                    n_out_year  = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_mon = r_mon + 1'b1;
                end
            end
            S_YEAR1: begin
                if (w_gt) begin
                    n_acc  = w_sum[CountW-1:0];
                    n_year = w_year_inc;
                    n_m4   = r_m4 + 2'd1;
                    n_m100 = (r_m100 == Mod100Last) ? 7'd0 : r_m100 + 7'd1;
                    n_m400 = (r_m400 == Mod400Last) ? 9'd0 : r_m400 + 9'd1;
                    if (w_year_inc > {1'b0, LastYear}) begin
                        n_valid     = 1'b1;
                        n_status    = STATUS_BAD_COUNT;
                        n_out_count = '0;
                        n_out_day   = '0;
                        n_out_month = '0;
                        n_out_year  = '0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_mon   = FirstMonth;
                    n_state = S_MON1;
                end
            end
            S_MON1: begin
                if ((r_mon != MonthsPerYear) && w_gt) begin
                    n_acc = w_sum[CountW-1:0];
                    n_mon = r_mon + 1'b1;
                end else begin
                    n_valid     = 1'b1;
                    n_status    = STATUS_OK;
                    n_out_count = '0;
                    n_out_day   = r_acc[DayW-1:0];
                    n_out_month = r_mon;
                    n_out_year  = r_year[YearW-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_day       <= n_day;
        r_month     <= n_month;
        r_year_tgt  <= n_year_tgt;
        r_year      <= n_year;
        r_mon       <= n_mon;
        r_acc       <= n_acc;
        r_m4        <= n_m4;
        r_m100      <= n_m100;
        r_m400      <= n_m400;
        r_status    <= n_status;
        r_out_count <= n_out_count;
        r_out_day   <= n_out_day;
        r_out_month <= n_out_month;
        r_out_year  <= n_out_year;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_out_count = r_out_count;
    assign o_out_day   = r_out_day;
    assign o_out_month = r_out_month;
    assign o_out_year  = r_out_year;

endmodule

[hw/rtl/edc_checker.sv]
// edc_port_assertions: port-level assertions for the epoch day date converter
// depends on edc_pkg; bound to epoch_day_date_converter below
module edc_port_assertions (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [edc_pkg::StatW-1:0]     o_status,
    input logic [edc_pkg::CountW-1:0]    o_out_count,
    input logic [edc_pkg::DayW-1:0]      o_out_day,
    input logic [edc_pkg::MonthW-1:0]    o_out_month,
    input logic [edc_pkg::YearW-1:0]     o_out_year
);
    import edc_pkg::*;

    // busy only follows an accepted item
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without start");

    // a result closes the item, so the block is free when it shows
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && ($past(start) || $past(busy)))
        else $error("result without an item in flight");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STATUS_OK)) |->
            (o_out_count == '0) && (o_out_day == '0) &&
            (o_out_month == '0) && (o_out_year == '0))
        else $error("error result with nonzero fields");

    // an ok result is either a day number or a full date, never both
    a_ok_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_OK)) |->
            ((o_out_count != '0) != (o_out_day != '0)))
        else $error("ok result mixes both kinds");

    a_ok_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STATUS_OK) && (o_out_day != '0)) |->
            (o_out_month >= FirstMonth) && (o_out_month <= MonthsPerYear))
        else $error("date result with month out of range");

endmodule

bind epoch_day_date_converter edc_port_assertions u_edc_port_assertions (.*);

[test/edc_checker.sv]
// edc_checker: watches the start/busy and o_valid channels of the epoch day date
// converter, predicts each conversion and compares it field by field
// depends on edc_pkg
`timescale 1ns / 1ps

module edc_checker #(
    parameter int MAX_YEAR = 4095
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       i_kind,
    input  logic [edc_pkg::DayW-1:0]   i_in_day,
    input  logic [edc_pkg::MonthW-1:0] i_in_month,
    input  logic [edc_pkg::YearW-1:0]  i_in_year,
    input  logic [edc_pkg::CountW-1:0] i_in_count,
    input  logic                       o_valid,
    input  logic [edc_pkg::StatW-1:0]  o_status,
    input  logic [edc_pkg::CountW-1:0] o_out_count,
    input  logic [edc_pkg::DayW-1:0]   o_out_day,
    input  logic [edc_pkg::MonthW-1:0] o_out_month,
    input  logic [edc_pkg::YearW-1:0]  o_out_year,
    output int                         mismatches,
    output int                         outstanding,
    output int                         rejected
);
    import edc_pkg::*;

    typedef struct packed {
        logic [StatW-1:0]  status;
        logic [CountW-1:0] count;
        logic [DayW-1:0]   day;
        logic [MonthW-1:0] month;
        logic [YearW-1:0]  year;
    } t_conversion;

    t_conversion expected_conversions[$];
    int          errs = 0;
    int          bad_status = 0;

    function automatic bit is_leap(int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int days_in_year(int yr);
        return is_leap(yr) ? 366 : 365;
    endfunction

    function automatic int days_in_month(int yr, int mo);
        case (mo)
            2:            return is_leap(yr) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic t_conversion calendar_convert(logic kind, int d, int m, int y, int c);
        t_conversion r;
        int          days;
        int          yr;
        int          mo;
        int          top_year;
        r = '0;
        if (kind == KIND_DATE_TO_DAYNUM) begin
            if (d == 0 || m == 0 || m > int'(MonthsPerYear) || y < int'(EpochYear) ||
                y > MAX_YEAR || d > days_in_month(y, m)) begin
                r.status = STATUS_BAD_DATE;
            end else begin
                days = 0;
                for (yr = int'(EpochYear); yr < y; yr++)
                    days += days_in_year(yr);
                for (mo = 1; mo < m; mo++)
                    days += days_in_month(y, mo);
                days += d;
                r.status = STATUS_OK;
                r.count  = days[CountW-1:0];
            end
        end else if (c == 0) begin
            r.status = STATUS_BAD_COUNT;
        end else begin
            top_year = (MAX_YEAR > YearTop) ? YearTop : MAX_YEAR;
            days     = c;
            yr       = int'(EpochYear);
            r.status = STATUS_OK;
            while (r.status == STATUS_OK && days > days_in_year(yr)) begin
                days -= days_in_year(yr);
                yr++;
                if (yr > top_year)
                    r.status = STATUS_BAD_COUNT;
            end
            if (r.status == STATUS_OK) begin
                mo = 1;
                while (mo < int'(MonthsPerYear) && days > days_in_month(yr, mo)) begin
                    days -= days_in_month(yr, mo);
                    mo++;
                end
                r.day   = days[DayW-1:0];
                r.month = mo[MonthW-1:0];
                r.year  = yr[YearW-1:0];
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        t_conversion want;
        if (i_rst_n) begin
            if (o_valid) begin
                if (expected_conversions.size() == 0) begin
                    $display("%0t: result with no item pending, status %0d", $time, o_status);
                    errs++;
                end else begin
                    want = expected_conversions.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("out_count", want.count, o_out_count);
                    check_field("out_day", want.day, o_out_day);
                    check_field("out_month", want.month, o_out_month);
                    check_field("out_year", want.year, o_out_year);
                    if (want.status != STATUS_OK)
                        bad_status++;
                end
            end
            if (start && !busy)
                expected_conversions.push_back(calendar_convert(i_kind, i_in_day, i_in_month,
                                                                i_in_year, i_in_count));
        end
        mismatches  <= errs;
        outstanding <= expected_conversions.size();
        rejected    <= bad_status;
    end

endmodule

[test/tb_top.sv]
// tb_top: drives directed and random conversions into the epoch day date converter
// and gives the verdict; depends on edc_pkg, epoch_day_date_converter and edc_checker
`timescale 1ns / 1ps

module tb_top;
    import edc_pkg::*;

    localparam int   MAX_YEAR            = 4095;
    localparam int   LAST_DAY_NUMBER     = 776506;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_kind;
    logic [DayW-1:0]   i_in_day;
    logic [MonthW-1:0] i_in_month;
    logic [YearW-1:0]  i_in_year;
    logic [CountW-1:0] i_in_count;
    logic              o_valid;
    logic [StatW-1:0]  o_status;
    logic [CountW-1:0] o_out_count;
    logic [DayW-1:0]   o_out_day;
    logic [MonthW-1:0] o_out_month;
    logic [YearW-1:0]  o_out_year;

    int mismatches;
    int outstanding;
    int rejected;
    int idle_pct;
    int date_items;
    int daynum_items;

    epoch_day_date_converter #(.MAX_YEAR(MAX_YEAR)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_in_day(i_in_day), .i_in_month(i_in_month),
        .i_in_year(i_in_year), .i_in_count(i_in_count),
        .o_valid(o_valid), .o_status(o_status), .o_out_count(o_out_count),
        .o_out_day(o_out_day), .o_out_month(o_out_month), .o_out_year(o_out_year)
    );

    edc_checker #(.MAX_YEAR(MAX_YEAR)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_in_day(i_in_day), .i_in_month(i_in_month),
        .i_in_year(i_in_year), .i_in_count(i_in_count),
        .o_valid(o_valid), .o_status(o_status), .o_out_count(o_out_count),
        .o_out_day(o_out_day), .o_out_month(o_out_month), .o_out_year(o_out_year),
        .mismatches(mismatches), .outstanding(outstanding), .rejected(rejected)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #30ms;
        $display("epoch_day_date_converter test failed");
        $finish;
    end

    task automatic send_item(logic kind, int d, int m, int y, int c);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_kind     <= kind;
        i_in_day   <= d[DayW-1:0];
        i_in_month <= m[MonthW-1:0];
        i_in_year  <= y[YearW-1:0];
        i_in_count <= c[CountW-1:0];
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (kind == KIND_DATE_TO_DAYNUM)
            date_items++;
        else
            daynum_items++;
    endtask

    task automatic send_date(int d, int m, int y);
        send_item(KIND_DATE_TO_DAYNUM, d, m, y, $urandom_range(0, 20'hFFFFF));
    endtask

    task automatic send_daynum(int c);
        send_item(KIND_DAYNUM_TO_DATE, $urandom_range(0, 31), $urandom_range(0, 15),
                  $urandom_range(0, 4095), c);
    endtask

    task automatic send_random();
        int r;
        int y;
        int d;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0) begin
            if (r < 75) begin
                y = (r < 55) ? $urandom_range(1970, 2100) : $urandom_range(1970, MAX_YEAR);
                d = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
                send_date(d, $urandom_range(1, 12), y);
            end else begin
                send_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 4095));
            end
        end else begin
            if (r < 55)
                send_daynum($urandom_range(1, 50000));
            else if (r < 80)
                send_daynum($urandom_range(1, LAST_DAY_NUMBER));
            else if (r < 90)
                send_daynum($urandom_range(LAST_DAY_NUMBER - 16, LAST_DAY_NUMBER + 16));
            else
                send_daynum($urandom_range(0, 20'hFFFFF));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_kind       = KIND_DATE_TO_DAYNUM;
        i_in_day     = '0;
        i_in_month   = '0;
        i_in_year    = '0;
        i_in_count   = '0;
        idle_pct     = 36;
        date_items   = 0;
        daynum_items = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_date(1, 1, 1970);
        send_date(31, 12, 1970);
        send_date(29, 2, 1972);
        send_date(29, 2, 1973);
        send_date(29, 2, 2000);
        send_date(29, 2, 2100);
        send_date(31, 12, MAX_YEAR);
        send_date(0, 5, 1980);
        send_date(10, 0, 1980);
        send_date(10, 13, 1980);
        send_date(31, 15, 1980);
        send_date(31, 4, 1990);
        send_date(31, 1, 1969);
        send_date(1, 1, 0);
        send_daynum(0);
        send_daynum(1);
        send_daynum(365);
        send_daynum(366);
        send_daynum(790);
        send_daynum(1096);
        send_daynum(LAST_DAY_NUMBER);
        send_daynum(LAST_DAY_NUMBER + 1);
        send_daynum(20'hFFFFF);

        repeat (82) send_random();
        idle_pct = 51;
        repeat (82) send_random();
        idle_pct = 0;
        repeat (82) send_random();
        start <= 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (2200) @(negedge i_clk);

        $display("converted %0d dates and %0d day numbers, %0d of them flagged as invalid",
                 date_items, daynum_items, rejected);
        $display("start held off in about 36%% of offer cycles, then 51%%, then back to back");
        if (mismatches == 0)
            $display("epoch_day_date_converter test passed");
        else
            $display("epoch_day_date_converter test failed");
        $finish;
    end

endmodule

[epoch_day_date_converter.f]
hw/rtl/edc_pkg.sv
hw/rtl/epoch_day_date_converter.sv
hw/rtl/edc_checker.sv
test/edc_checker.sv
test/tb_top.sv
